// ----- rtl/core/point_pair_measure_top_macros.svh -----
// Assertion helpers shared by the point pair measurement RTL.
// Each helper takes a label, the clock, the reset, a condition and a consequence.
`ifndef POINT_PAIR_MEASURE_TOP_MACROS_SVH
`define POINT_PAIR_MEASURE_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define PPM_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("point pair measure: same-cycle check failed");
`define PPM_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("point pair measure: next-cycle check failed");
`else
`define PPM_ASSERT_IMPL(name, clk, rst, ante, cons)
`define PPM_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/core/ppm_pkg.sv -----
`default_nettype none

package ppm_pkg;

  // Fixed field widths of the words on the channels.
  localparam int IN_W    = 32;
  localparam int DIST_BITS = 35;
  localparam int ELEV_W  = 15;
  localparam int REG_W   = 48;
  localparam int COEF_W  = 16;
  localparam int LANES   = 3;

  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

  // Defaults for the top level parameters.
  localparam int COORD_WIDTH_DEF   = 32;
  localparam int COEF_FRAC_DEF     = 14;
  localparam int CORDIC_STAGES_DEF = 16;

  // Square root lanes: 72-bit radicand, one root bit per cell.
  localparam int SQ_BITS   = 72;
  localparam int ROOT_BITS = SQ_BITS / 2;
  localparam int REM_W     = ROOT_BITS + 3;
  localparam int RT_W      = ROOT_BITS + 1;

  // CORDIC datapath.
  localparam int CORDIC_GUARD = 20;
  localparam int ANGLE_FRAC   = 16;
  localparam int ANG_W        = 32;
  localparam int CX_W         = RT_W + CORDIC_GUARD + 2;
  localparam int ANGLE_LIMIT  = 9000;
  localparam logic signed [ANG_W-1:0] ANG_CLAMP = ANG_W'(ANGLE_LIMIT) <<< ANGLE_FRAC;

  // Matrix column reset values: the identity in Q2.14.
  localparam logic [REG_W-1:0] COL_X_RESET = 48'h0000_0000_4000;
  localparam logic [REG_W-1:0] COL_Y_RESET = 48'h0000_4000_0000;
  localparam logic [REG_W-1:0] COL_Z_RESET = 48'h4000_0000_0000;

  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COL_X = 2'd0,
    CFG_COL_Y = 2'd1,
    CFG_COL_Z = 2'd2
  } cfg_index_t;

  // atan(2^-i) in hundredths of a degree, scaled by 2^16.
  localparam logic signed [ANG_W-1:0] ATAN_UNITS [0:31] = '{
    32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507, 32'sd23437865,
    32'sd11730358, 32'sd5866610, 32'sd2933484, 32'sd1466764, 32'sd733385,
    32'sd366693, 32'sd183346, 32'sd91673, 32'sd45837, 32'sd22918, 32'sd11459,
    32'sd5730, 32'sd2865, 32'sd1432, 32'sd716, 32'sd358, 32'sd179, 32'sd90,
    32'sd45, 32'sd22, 32'sd11, 32'sd6, 32'sd3, 32'sd1, 32'sd1, 32'sd0, 32'sd0
  };

  function automatic logic signed [ANG_W-1:0] atan_unit(input logic [4:0] i);
    return ATAN_UNITS[i];
  endfunction

  typedef struct packed {
    logic [SQ_BITS-1:0] rad;
    logic [REM_W-1:0]   rem;
    logic [RT_W-1:0]    root;
  } root_lane_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] lxc;
    logic [DIST_BITS-1:0] lyc;
    logic [DIST_BITS-1:0] lzc;
    logic [DIST_BITS-1:0] zs;
    logic                 hsat;
    logic                 zzero;
    logic                 nz;
  } root_side_t;

  typedef struct packed {
    logic signed [CX_W-1:0]  cx;
    logic signed [CX_W-1:0]  cy;
    logic signed [ANG_W-1:0] ang;
  } cordic_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] total;
    logic [DIST_BITS-1:0] lx;
    logic [DIST_BITS-1:0] ly;
    logic [DIST_BITS-1:0] lz;
    logic [DIST_BITS-1:0] horiz;
    logic                 zzero;
    logic                 nz;
    logic                 hzero;
  } cordic_side_t;

endpackage

`default_nettype wire

// ----- rtl/core/ppm_in_if.sv -----
`default_nettype none

interface ppm_in_if import ppm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] start_x;
  logic [IN_W-1:0] start_y;
  logic [IN_W-1:0] start_z;
  logic [IN_W-1:0] end_x;
  logic [IN_W-1:0] end_y;
  logic [IN_W-1:0] end_z;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ppm_out_if.sv -----
`default_nettype none

interface ppm_out_if import ppm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [DIST_BITS-1:0] total_length;
  logic [DIST_BITS-1:0] local_x_extent;
  logic [DIST_BITS-1:0] local_y_extent;
  logic [DIST_BITS-1:0] local_z_extent;
  logic [DIST_BITS-1:0] horizontal_length;
  logic [ELEV_W-1:0]    elevation_angle;

  modport source (output valid, total_length, local_x_extent, local_y_extent,
                  local_z_extent, horizontal_length, elevation_angle,
                  input ready);
  modport sink (input valid, total_length, local_x_extent, local_y_extent,
                local_z_extent, horizontal_length, elevation_angle,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ppm_front.sv -----
`default_nettype none

module ppm_front import ppm_pkg::*; #(
  parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  ppm_in_if.sink                       in_ch,
  input  wire logic [REG_W-1:0]        col_x,
  input  wire logic [REG_W-1:0]        col_y,
  input  wire logic [REG_W-1:0]        col_z,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output root_lane_t [LANES-1:0]       lane,
  output root_side_t                   side
);

  localparam int CVW  = (COORD_WIDTH < IN_W) ? COORD_WIDTH :
                        ((COORD_WIDTH == IN_W) ? IN_W : IN_W + 1);
  localparam int DW   = CVW + 1;
  localparam int PW   = DW + COEF_W;
  localparam int AW   = PW + 2;
  localparam int MW   = AW - COEF_FRAC_BITS;
  localparam int MAGW = (MW > DIST_BITS) ? MW : DIST_BITS;
  localparam int SHN  = MAGW - DIST_BITS;
  localparam int SHW  = (SHN > 0) ? $clog2(SHN + 1) : 1;
  localparam int SQW  = 2 * (DW - 1);
  localparam int TW   = SQW + 2;
  localparam int HW   = 2 * DIST_BITS;
  localparam int NSTG = 7;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] rdy;
  logic [NSTG-1:0] vld_in;

  assign vld_in = {vld[NSTG-2:0], in_ch.valid};
  assign rdy[NSTG-1] = !vld[NSTG-1] || out_ready;
  for (genvar s = 0; s < NSTG - 1; s++) begin : g_rdy
    assign rdy[s] = !vld[s] || rdy[s+1];
  end
  assign in_ch.ready = rdy[0];
  assign out_valid   = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int s = 0; s < NSTG; s++) begin
        if (rdy[s]) begin
          vld[s] <= vld_in[s];
        end
      end
    end
  end

  // Coordinates as signed values.
  logic signed [CVW-1:0] cs [LANES];
  logic signed [CVW-1:0] ce [LANES];

  if (COORD_WIDTH <= IN_W) begin : g_narrow
    assign cs[0] = $signed(in_ch.start_x[CVW-1:0]);
    assign cs[1] = $signed(in_ch.start_y[CVW-1:0]);
    assign cs[2] = $signed(in_ch.start_z[CVW-1:0]);
    assign ce[0] = $signed(in_ch.end_x[CVW-1:0]);
    assign ce[1] = $signed(in_ch.end_y[CVW-1:0]);
    assign ce[2] = $signed(in_ch.end_z[CVW-1:0]);
  end else begin : g_wide
    assign cs[0] = $signed({1'b0, in_ch.start_x});
    assign cs[1] = $signed({1'b0, in_ch.start_y});
    assign cs[2] = $signed({1'b0, in_ch.start_z});
    assign ce[0] = $signed({1'b0, in_ch.end_x});
    assign ce[1] = $signed({1'b0, in_ch.end_y});
    assign ce[2] = $signed({1'b0, in_ch.end_z});
  end

  logic [REG_W-1:0] cols [LANES];
  assign cols[0] = col_x;
  assign cols[1] = col_y;
  assign cols[2] = col_z;

  // Stage 1: difference vector.
  logic signed [DW-1:0] d1 [LANES];
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int c = 0; c < LANES; c++) begin
        d1[c] <= DW'(ce[c]) - DW'(cs[c]);
      end
    end
  end

  // Stage 2: the nine matrix products and the three squares.
  logic signed [PW-1:0] p2 [LANES][LANES];
  logic [SQW-1:0]       q2 [LANES];
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int r = 0; r < LANES; r++) begin
        for (int c = 0; c < LANES; c++) begin
          p2[r][c] <= PW'(d1[c]) * PW'($signed(cols[c][COEF_W*r +: COEF_W]));
        end
      end
      for (int c = 0; c < LANES; c++) begin
        q2[c] <= SQW'(d1[c]) * SQW'(d1[c]);
      end
    end
  end

  // Stage 3: row sums and the sum of squares.
  logic signed [AW-1:0] a3 [LANES];
  logic [TW-1:0]        t3;
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int r = 0; r < LANES; r++) begin
        a3[r] <= AW'(p2[r][0]) + AW'(p2[r][1]) + AW'(p2[r][2]);
      end
      t3 <= TW'(q2[0]) + TW'(q2[1]) + TW'(q2[2]);
    end
  end

  // Stage 4: rounded magnitudes of the local components.
  logic [AW-1:0]   am  [LANES];
  logic [AW-1:0]   rm  [LANES];
  logic [MW-1:0]   mg  [LANES];
  logic [MAGW-1:0] mag4 [LANES];
  logic            nz4;
  logic [TW-1:0]   t4;

  always_comb begin
    for (int r = 0; r < LANES; r++) begin
      am[r] = a3[r][AW-1] ? AW'(-a3[r]) : AW'(a3[r]);
      rm[r] = am[r] + (AW'(1) << (COEF_FRAC_BITS - 1));
      mg[r] = rm[r][AW-1:COEF_FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int r = 0; r < LANES; r++) begin
        mag4[r] <= MAGW'(mg[r]);
      end
      nz4 <= a3[2][AW-1] && (mg[2] != '0);
      t4  <= t3;
    end
  end

  // Stage 5: common scaling for the angle path and clamped extents.
  logic [MAGW-1:0]      mor;
  logic [SHW-1:0]       sh;
  logic [MAGW-1:0]      xsh, ysh, zsh;
  logic [DIST_BITS-1:0] cl [LANES];
  logic [DIST_BITS-1:0] xs5, ys5;
  logic [TW-1:0]        t5;
  root_side_t           side5;

  always_comb begin
    mor = mag4[0] | mag4[1] | mag4[2];
    sh  = '0;
    for (int j = 1; j <= SHN; j++) begin
      if ((mor >> (j - 1)) > MAGW'(DIST_MAX)) begin
        sh = SHW'(j);
      end
    end
    xsh = mag4[0] >> sh;
    ysh = mag4[1] >> sh;
    zsh = mag4[2] >> sh;
    for (int r = 0; r < LANES; r++) begin
      cl[r] = (mag4[r] > MAGW'(DIST_MAX)) ? DIST_MAX : mag4[r][DIST_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      xs5         <= xsh[DIST_BITS-1:0];
      ys5         <= ysh[DIST_BITS-1:0];
      t5          <= t4;
      side5.lxc   <= cl[0];
      side5.lyc   <= cl[1];
      side5.lzc   <= cl[2];
      side5.zs    <= zsh[DIST_BITS-1:0];
      side5.hsat  <= (mag4[0] > MAGW'(DIST_MAX)) || (mag4[1] > MAGW'(DIST_MAX));
      side5.zzero <= (mag4[2] == '0);
      side5.nz    <= nz4;
    end
  end

  // Stage 6: squares for the two horizontal lengths.
  logic [HW-1:0] s6 [4];
  logic [TW-1:0] t6;
  root_side_t    side6;
  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s6[0] <= HW'(side5.lxc) * HW'(side5.lxc);
      s6[1] <= HW'(side5.lyc) * HW'(side5.lyc);
      s6[2] <= HW'(xs5) * HW'(xs5);
      s6[3] <= HW'(ys5) * HW'(ys5);
      t6    <= t5;
      side6 <= side5;
    end
  end

  // Stage 7: radicands of the three roots.
  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      lane[0].rad <= SQ_BITS'(t6);
      lane[1].rad <= SQ_BITS'(s6[0]) + SQ_BITS'(s6[1]);
      lane[2].rad <= SQ_BITS'(s6[2]) + SQ_BITS'(s6[3]);
      for (int l = 0; l < LANES; l++) begin
        lane[l].rem  <= '0;
        lane[l].root <= '0;
      end
      side <= side6;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ppm_root_cell.sv -----
`default_nettype none

module ppm_root_cell import ppm_pkg::*; #(
  parameter int POS   = 0,
  parameter bit FINAL = 1'b0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  root_lane_t [LANES-1:0] in_lane,
  input  root_side_t             in_side,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output root_lane_t [LANES-1:0] out_lane,
  output root_side_t             out_side
);

  root_lane_t [LANES-1:0] nxt;

  if (FINAL) begin : g_round
    // Round to nearest: bump the root when the remainder exceeds it.
    always_comb begin
      nxt = in_lane;
      for (int l = 0; l < LANES; l++) begin
        if (in_lane[l].rem > REM_W'(in_lane[l].root)) begin
          nxt[l].root = in_lane[l].root + RT_W'(1);
        end
      end
    end
  end else begin : g_step
    logic [REM_W-1:0] remsh [LANES];
    logic [REM_W-1:0] trial [LANES];
    always_comb begin
      nxt = in_lane;
      for (int l = 0; l < LANES; l++) begin
        remsh[l] = {in_lane[l].rem[REM_W-3:0], in_lane[l].rad[2*POS+1 -: 2]};
        trial[l] = {in_lane[l].root, 2'b01};
        if (remsh[l] >= trial[l]) begin
          nxt[l].rem  = remsh[l] - trial[l];
          nxt[l].root = {in_lane[l].root[RT_W-2:0], 1'b1};
        end else begin
          nxt[l].rem  = remsh[l];
          nxt[l].root = {in_lane[l].root[RT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_lane <= nxt;
      out_side <= in_side;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ppm_cordic_cell.sv -----
`default_nettype none

module ppm_cordic_cell import ppm_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  cordic_t     in_vec,
  input  cordic_side_t in_side,
  output logic        out_valid,
  input  wire logic   out_ready,
  output cordic_t     out_vec,
  output cordic_side_t out_side
);

  logic signed [CX_W-1:0] xs, ys;
  cordic_t nxt;

  // Vectoring step: rotate towards the x axis and accumulate the angle.
  always_comb begin
    xs = in_vec.cx >>> IDX;
    ys = in_vec.cy >>> IDX;
    if (!in_vec.cy[CX_W-1]) begin
      nxt.cx  = in_vec.cx + ys;
      nxt.cy  = in_vec.cy - xs;
      nxt.ang = in_vec.ang + atan_unit(5'(IDX));
    end else begin
      nxt.cx  = in_vec.cx - ys;
      nxt.cy  = in_vec.cy + xs;
      nxt.ang = in_vec.ang - atan_unit(5'(IDX));
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_vec  <= nxt;
      out_side <= in_side;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/point_pair_measure_top.sv -----
`default_nettype none

// Point pair measurement. Each input word carries an origin and an end point
// in signed 0.1 mm units; the block returns one output word per input word
// with the rounded Euclidean length of the difference, the absolute components
// of that difference rotated by the 3x3 matrix held in the three column
// registers (signed Q2.14 by default, reset to the identity), the length of
// the rotated x/y pair and the elevation angle in hundredths of a degree.
// Distances saturate at 2^35 - 1. The block takes one word every clock cycle
// while the output is not stalled. Words pass through seven front stages for
// the difference, matrix product and squares, 36 square root cells retiring
// one root bit each plus a rounding cell, one CORDIC cell per angle iteration
// and the output register. The column registers may be written only while no
// word is in flight.

`include "point_pair_measure_top_macros.svh"

module point_pair_measure_top import ppm_pkg::*; #(
  parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEF,
  parameter int CORDIC_STAGES  = CORDIC_STAGES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  ppm_in_if.sink                    in_ch,
  ppm_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0]     cfg_data
);

  localparam int NROOT = ROOT_BITS + 1;

  // Matrix column registers. Writes to an index with no register are dropped.
  logic [REG_W-1:0] col_x, col_y, col_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_x <= COL_X_RESET;
      col_y <= COL_Y_RESET;
      col_z <= COL_Z_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_COL_X: col_x <= cfg_data;
        CFG_COL_Y: col_y <= cfg_data;
        CFG_COL_Z: col_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: difference, rotation, rounding and radicands.
  logic                   rv [0:NROOT];
  logic                   rr [0:NROOT];
  root_lane_t [LANES-1:0] rl [0:NROOT];
  root_side_t             rs [0:NROOT];

  ppm_front #(
    .COORD_WIDTH    (COORD_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .col_x     (col_x),
    .col_y     (col_y),
    .col_z     (col_z),
    .out_valid (rv[0]),
    .out_ready (rr[0]),
    .lane      (rl[0]),
    .side      (rs[0])
  );

  // Square root chain: the total length, the horizontal length and the
  // horizontal length of the rescaled vector for the angle, side by side.
  for (genvar j = 0; j < NROOT; j++) begin : g_root
    ppm_root_cell #(
      .POS   ((j < ROOT_BITS) ? (ROOT_BITS - 1 - j) : 0),
      .FINAL (j == ROOT_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (rv[j]),
      .in_ready  (rr[j]),
      .in_lane   (rl[j]),
      .in_side   (rs[j]),
      .out_valid (rv[j+1]),
      .out_ready (rr[j+1]),
      .out_lane  (rl[j+1]),
      .out_side  (rs[j+1])
    );
  end

  // Hand-over to the CORDIC: clamp the lengths and load the start vector.
  logic         cv [0:CORDIC_STAGES];
  logic         cr [0:CORDIC_STAGES];
  cordic_t      cd [0:CORDIC_STAGES];
  cordic_side_t cs [0:CORDIC_STAGES];

  always_comb begin
    cs[0].total = (rl[NROOT][0].root > RT_W'(DIST_MAX)) ? DIST_MAX :
                  rl[NROOT][0].root[DIST_BITS-1:0];
    cs[0].horiz = (rs[NROOT].hsat || (rl[NROOT][1].root > RT_W'(DIST_MAX))) ? DIST_MAX :
                  rl[NROOT][1].root[DIST_BITS-1:0];
    cs[0].lx    = rs[NROOT].lxc;
    cs[0].ly    = rs[NROOT].lyc;
    cs[0].lz    = rs[NROOT].lzc;
    cs[0].zzero = rs[NROOT].zzero;
    cs[0].nz    = rs[NROOT].nz;
    cs[0].hzero = (rl[NROOT][2].root == '0);
    cd[0].cx    = CX_W'({rl[NROOT][2].root, {CORDIC_GUARD{1'b0}}});
    cd[0].cy    = CX_W'({rs[NROOT].zs, {CORDIC_GUARD{1'b0}}});
    cd[0].ang   = '0;
  end

  assign cv[0]     = rv[NROOT];
  assign rr[NROOT] = cr[0];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    ppm_cordic_cell #(
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[i]),
      .in_ready  (cr[i]),
      .in_vec    (cd[i]),
      .in_side   (cs[i]),
      .out_valid (cv[i+1]),
      .out_ready (cr[i+1]),
      .out_vec   (cd[i+1]),
      .out_side  (cs[i+1])
    );
  end

  // Output register. The accumulated angle is clamped to the first quadrant,
  // rounded to whole hundredths and given the sign of local z. A zero local z
  // gives a flat angle, and a zero horizontal length a vertical one.
  logic signed [ANG_W-1:0] ac;
  logic signed [ANG_W-1:0] arnd;
  logic [ELEV_W-1:0]       amag;
  logic [ELEV_W-1:0]       elev;

  always_comb begin
    ac = cd[CORDIC_STAGES].ang;
    if (ac < 0) begin
      ac = '0;
    end
    if (ac > ANG_CLAMP) begin
      ac = ANG_CLAMP;
    end
    arnd = ac + (ANG_W'(1) <<< (ANGLE_FRAC - 1));
    amag = arnd[ANGLE_FRAC +: ELEV_W];
    priority if (cs[CORDIC_STAGES].zzero) begin
      elev = '0;
    end else if (cs[CORDIC_STAGES].hzero) begin
      elev = cs[CORDIC_STAGES].nz ? ELEV_W'(-ANGLE_LIMIT) : ELEV_W'(ANGLE_LIMIT);
    end else begin
      elev = cs[CORDIC_STAGES].nz ? ELEV_W'(-amag) : amag;
    end
  end

  assign cr[CORDIC_STAGES] = !out_ch.valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (cr[CORDIC_STAGES]) begin
      out_ch.valid <= cv[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (cr[CORDIC_STAGES]) begin
      out_ch.total_length      <= cs[CORDIC_STAGES].total;
      out_ch.local_x_extent    <= cs[CORDIC_STAGES].lx;
      out_ch.local_y_extent    <= cs[CORDIC_STAGES].ly;
      out_ch.local_z_extent    <= cs[CORDIC_STAGES].lz;
      out_ch.horizontal_length <= cs[CORDIC_STAGES].horiz;
      out_ch.elevation_angle   <= elev;
    end
  end

  // A word with no local z height must report a flat angle.
  `PPM_ASSERT_IMPL(a_flat_when_no_z, clk, rst,
    out_ch.valid && (out_ch.local_z_extent == '0), out_ch.elevation_angle == '0)
  // The angle never leaves the vertical limits.
  `PPM_ASSERT_IMPL(a_angle_in_range, clk, rst, out_ch.valid,
    ($signed(out_ch.elevation_angle) <= $signed(ELEV_W'(ANGLE_LIMIT))) &&
    ($signed(out_ch.elevation_angle) >= $signed(ELEV_W'(-ANGLE_LIMIT))))
  // No horizontal extent with some height means a vertical measurement.
  `PPM_ASSERT_IMPL(a_vertical, clk, rst,
    out_ch.valid && (out_ch.horizontal_length == '0) && (out_ch.local_z_extent != '0),
    (out_ch.elevation_angle == ELEV_W'(ANGLE_LIMIT)) ||
    (out_ch.elevation_angle == ELEV_W'(-ANGLE_LIMIT)))
  // A word held at the output is not overwritten by the CORDIC chain.
  `PPM_ASSERT_NEXT(a_out_held, clk, rst, out_ch.valid && !out_ch.ready,
    out_ch.valid && $stable(out_ch.elevation_angle) && $stable(out_ch.total_length))

endmodule

`default_nettype wire
